### rtl/hmss_pkg.sv
// Shared types, codes and constants of the height map store and sampler.
package hmss_pkg;

   // Store geometry and sample constants.
   localparam int MAX_VERTICES   = 262144;
   localparam int VERTEX_GAP     = 32;
   localparam int CHUNK_VERTICES = 10;
   localparam int ADDR_W         = $clog2(MAX_VERTICES);
   localparam int GAP_SHIFT      = $clog2(VERTEX_GAP);
   localparam int FRAC_W         = 8;
   localparam int CELL_W         = FRAC_W + GAP_SHIFT;
   localparam int CHUNK_OFFSET   = CHUNK_VERTICES * VERTEX_GAP;

   // Request kinds.
   localparam logic [2:0] KIND_WRITE   = 3'd0;
   localparam logic [2:0] KIND_RAISE   = 3'd1;
   localparam logic [2:0] KIND_LOWER   = 3'd2;
   localparam logic [2:0] KIND_READ    = 3'd3;
   localparam logic [2:0] KIND_SAMPLE  = 3'd4;
   localparam logic [2:0] KIND_CLEAR   = 3'd5;
   localparam logic [2:0] KIND_SPARE_A = 3'd6;
   localparam logic [2:0] KIND_SPARE_B = 3'd7;

   // Register indexes of the control port.
   localparam logic [2:0] CSR_ROW_VERTICES = 3'd0;
   localparam logic [2:0] CSR_MAP_WIDTH    = 3'd1;
   localparam logic [2:0] CSR_MAP_HEIGHT   = 3'd2;
   localparam logic [2:0] CSR_BASE_HEIGHT  = 3'd3;
   localparam logic [2:0] CSR_WATER_LEVEL  = 3'd4;
   localparam logic [2:0] CSR_VERTEX_COUNT = 3'd5;

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_RAISE,
      OP_LOWER,
      OP_READ,
      OP_SAMPLE,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic [2:0]          kind;
      logic [17:0]         vertex_index;
      logic signed [15:0]  amount;
      logic signed [15:0]  bound;
      logic [23:0]         sample_x;
      logic [23:0]         sample_y;
   } req_type;

   typedef struct packed {
      logic signed [24:0]  result_value;
      logic                valid_res;
      logic                passable;
      logic signed [15:0]  lowest_seen;
      logic signed [15:0]  highest_seen;
   } rsp_type;

   typedef struct packed {
      logic [10:0]         row_vertices;
      logic [15:0]         map_width;
      logic [15:0]         map_height;
      logic signed [15:0]  base_height;
      logic signed [15:0]  water_level;
      logic [18:0]         vertex_count;
   } cfg_type;

   // One classified request waiting in the queue.
   typedef struct packed {
      op_type   op;
      req_type  req;
   } job_type;

endpackage

### rtl/heightmap_store_and_sampler_core.sv
// Top level of the height map store and sampler: control registers and the two halves.
//
// Requests enter on req_valid/req_ready and carry a kind: write, raise, lower,
// read, sample or clear. Every request yields one response on rsp_valid/rsp_ready.
// Control registers are written on csr_valid/csr_ready (always ready) by index.
// Write them only while no request is outstanding; the block does not enforce it.
// A front queue of two requests lets new requests be taken while the back end
// works or while a finished response waits for the receiver.
// The back end serves one request at a time through its single height memory port:
// write, raise, lower and read pass read and update states; a sample passes
// index, read, multiply and accumulate states per corner, then a finish state,
// ending early if a corner lies outside the map; a clear writes each filled vertex.
// After reset the memory is set to zero, while req_ready stays low. When the
// receiver stalls, the response is held and the back end waits before starting
// the next request; the queue then fills.
module heightmap_store_and_sampler_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hmss_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hmss_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);

   hmss_pkg::cfg_type cfg_ff, cfg_in;
   hmss_pkg::job_type job_data;
   logic              job_valid, job_pop, init_busy;

   assign csr_ready = 1'b1;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            hmss_pkg::CSR_ROW_VERTICES: cfg_in.row_vertices = csr_data[10:0];
            hmss_pkg::CSR_MAP_WIDTH:    cfg_in.map_width    = csr_data[15:0];
            hmss_pkg::CSR_MAP_HEIGHT:   cfg_in.map_height   = csr_data[15:0];
            hmss_pkg::CSR_BASE_HEIGHT:  cfg_in.base_height  = csr_data[15:0];
            hmss_pkg::CSR_WATER_LEVEL:  cfg_in.water_level  = csr_data[15:0];
            hmss_pkg::CSR_VERTEX_COUNT: cfg_in.vertex_count = csr_data[18:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{row_vertices: 11'd480, map_width: 16'd15360, map_height: 16'd10240,
                     base_height: 16'sd0, water_level: 16'sd0, vertex_count: 19'd153600};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hmss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .init_busy (init_busy),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop)
   );

   hmss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/hmss_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module hmss_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hmss_pkg::req_type req_data,
   input  logic             init_busy,
   output logic             job_valid,
   output hmss_pkg::job_type job_data,
   input  logic             job_pop
);

   hmss_pkg::job_type slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   hmss_pkg::op_type op;

   // Decode the kind into an operation.
   always_comb begin
      case (req_data.kind)
         hmss_pkg::KIND_WRITE:  op = hmss_pkg::OP_WRITE;
         hmss_pkg::KIND_RAISE:  op = hmss_pkg::OP_RAISE;
         hmss_pkg::KIND_LOWER:  op = hmss_pkg::OP_LOWER;
         hmss_pkg::KIND_READ:   op = hmss_pkg::OP_READ;
         hmss_pkg::KIND_SAMPLE: op = hmss_pkg::OP_SAMPLE;
         hmss_pkg::KIND_CLEAR:  op = hmss_pkg::OP_CLEAR;
         default:               op = hmss_pkg::OP_NONE;
      endcase
   end

   // Two-entry queue; no request is taken while the store is being initialized.
   assign req_ready = (count_ff != 2'd2) && !init_busy;
   assign push      = req_valid && req_ready;
   assign job_valid = (count_ff != 2'd0);
   assign job_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = job_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(job_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{op: op, req: req_data};
      end
   end

endmodule

### rtl/hmss_back.sv
// Back end: height memory, update, sample and clear sequencing, result register.
module hmss_back (
   input  logic              clock,
   input  logic              reset,
   input  hmss_pkg::cfg_type cfg,
   input  logic              job_valid,
   input  hmss_pkg::job_type job_data,
   output logic              job_pop,
   output logic              init_busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hmss_pkg::rsp_type rsp_data
);

   localparam int AW = hmss_pkg::ADDR_W;
   localparam int CW = hmss_pkg::CELL_W;

   typedef enum logic [9:0] {
      ST_INIT = 10'b0000000001,
      ST_IDLE = 10'b0000000010,
      ST_RD   = 10'b0000000100,
      ST_UPD  = 10'b0000001000,
      ST_SIDX = 10'b0000010000,
      ST_SRD  = 10'b0000100000,
      ST_SMUL = 10'b0001000000,
      ST_SACC = 10'b0010000000,
      ST_SFIN = 10'b0100000000,
      ST_CLR  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] mem [hmss_pkg::MAX_VERTICES];
   logic signed [15:0] rdata_ff;
   logic [AW-1:0]      addr;
   logic               we;
   logic signed [15:0] wdata;

   hmss_pkg::job_type  cur_ff, cur_in;
   logic [AW:0]        cnt_ff, cnt_in;
   logic [AW:0]        limit_ff, limit_in;
   logic signed [15:0] fill_ff, fill_in;
   logic [1:0]         k_ff, k_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [2*(CW+1)-1:0] w_ff, w_in;
   logic signed [44:0] prod_ff, prod_in;
   logic signed [44:0] acc_ff, acc_in;
   logic signed [15:0] low_ff, low_in, high_ff, high_in;
   logic               rsp_valid_ff, rsp_valid_in;
   hmss_pkg::rsp_type  rsp_ff, rsp_in;

   // Sample corner geometry for corner k.
   logic [15:0]        x0, y0;
   logic [16:0]        cx, cy;
   logic [17:0]        sx_off, sy_off;
   logic [12:0]        ix, iy;
   logic [23:0]        row_term;
   logic [24:0]        lin;
   logic               corner_ok;
   logic [CW-1:0]      fa, fb;
   logic [CW:0]        wa, wb, na, nb;

   // Height update of write, raise and lower.
   logic signed [16:0] t;
   logic signed [15:0] hnew;
   logic signed [44:0] rnd, q;
   logic [AW:0]        clear_n;

   assign x0 = cur_ff.req.sample_x[23:8];
   assign y0 = cur_ff.req.sample_y[23:8];

   always_comb begin
      cx = {1'b0, x0} + ((k_ff == 2'd1 || k_ff == 2'd2) ?
                         17'(hmss_pkg::VERTEX_GAP) : 17'd0);
      cy = {1'b0, y0} + ((k_ff == 2'd2 || k_ff == 2'd3) ?
                         17'(hmss_pkg::VERTEX_GAP) : 17'd0);
      sx_off = {1'b0, cx} + 18'(hmss_pkg::CHUNK_OFFSET);
      sy_off = {1'b0, cy} + 18'(hmss_pkg::CHUNK_OFFSET);
      ix = 13'(sx_off >> hmss_pkg::GAP_SHIFT);
      iy = 13'(sy_off >> hmss_pkg::GAP_SHIFT);
      row_term = 24'(iy) * 24'(cfg.row_vertices);
      lin = 25'(ix) + 25'(row_term);
      corner_ok = (cx < {1'b0, cfg.map_width}) && (cy < {1'b0, cfg.map_height})
                  && (lin < 25'(hmss_pkg::MAX_VERTICES));
      fa = cur_ff.req.sample_x[CW-1:0];
      fb = cur_ff.req.sample_y[CW-1:0];
      na = (CW+1)'(1 << CW) - {1'b0, fa};
      nb = (CW+1)'(1 << CW) - {1'b0, fb};
      wa = (k_ff == 2'd1 || k_ff == 2'd2) ? {1'b0, fa} : na;
      wb = (k_ff == 2'd2 || k_ff == 2'd3) ? {1'b0, fb} : nb;
   end

   always_comb begin
      t = {rdata_ff[15], rdata_ff};
      case (cur_ff.op)
         hmss_pkg::OP_WRITE: t = {cur_ff.req.amount[15], cur_ff.req.amount};
         hmss_pkg::OP_RAISE: begin
            t = {rdata_ff[15], rdata_ff} + {cur_ff.req.amount[15], cur_ff.req.amount};
            if (t > $signed({cur_ff.req.bound[15], cur_ff.req.bound})) begin
               t = {cur_ff.req.bound[15], cur_ff.req.bound};
            end
         end
         hmss_pkg::OP_LOWER: begin
            t = {rdata_ff[15], rdata_ff} - {cur_ff.req.amount[15], cur_ff.req.amount};
            if (t < $signed({cur_ff.req.bound[15], cur_ff.req.bound})) begin
               t = {cur_ff.req.bound[15], cur_ff.req.bound};
            end
         end
         default: t = {rdata_ff[15], rdata_ff};
      endcase
      if (t > 17'sd32767) begin
         hnew = 16'sh7fff;
      end else if (t < -17'sd32768) begin
         hnew = 16'sh8000;
      end else begin
         hnew = t[15:0];
      end
   end

   // Round the blend to 8 fraction bits and remove the base height.
   always_comb begin
      rnd = acc_ff + 45'sd131072;
      q = (rnd >>> (2 * CW - hmss_pkg::FRAC_W)) -
          (45'(cfg.base_height) <<< hmss_pkg::FRAC_W);
   end

   assign clear_n = (cfg.vertex_count > 19'(hmss_pkg::MAX_VERTICES)) ?
                    (AW+1)'(hmss_pkg::MAX_VERTICES) : (AW+1)'(cfg.vertex_count);

   // Memory port selection.
   always_comb begin
      addr  = cur_ff.req.vertex_index[AW-1:0];
      we    = 1'b0;
      wdata = hnew;
      if (state_ff == ST_SRD) begin
         addr = idx_ff;
      end else if (state_ff == ST_INIT || state_ff == ST_CLR) begin
         addr  = cnt_ff[AW-1:0];
         wdata = fill_ff;
         we    = (cnt_ff != limit_ff);
      end else if (state_ff == ST_UPD) begin
         we = (cur_ff.op != hmss_pkg::OP_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      limit_in     = limit_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      w_in         = w_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      job_pop      = 1'b0;
      case (state_ff)
         ST_INIT, ST_CLR: begin
            if (cnt_ff == limit_ff) begin
               state_in = ST_IDLE;
               if (state_ff == ST_CLR) begin
                  low_in       = cfg.base_height;
                  high_in      = cfg.base_height;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{result_value: '0, valid_res: 1'b1, passable: 1'b0,
                                   lowest_seen: cfg.base_height,
                                   highest_seen: cfg.base_height};
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (job_valid && !rsp_valid_ff) begin
               job_pop = 1'b1;
               cur_in  = job_data;
               k_in    = 2'd0;
               acc_in  = '0;
               cnt_in  = '0;
               case (job_data.op)
                  hmss_pkg::OP_WRITE, hmss_pkg::OP_RAISE, hmss_pkg::OP_LOWER,
                  hmss_pkg::OP_READ: state_in = ST_RD;
                  hmss_pkg::OP_SAMPLE: state_in = ST_SIDX;
                  hmss_pkg::OP_CLEAR: begin
                     state_in = ST_CLR;
                     limit_in = clear_n;
                     fill_in  = cfg.base_height;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{result_value: '0, valid_res: 1'b0, passable: 1'b0,
                                lowest_seen: low_ff, highest_seen: high_ff};
                  end
               endcase
            end
         end
         ST_RD: state_in = ST_UPD;
         ST_UPD: begin
            state_in = ST_IDLE;
            if (cur_ff.op != hmss_pkg::OP_READ) begin
               if (hnew < low_ff) low_in = hnew;
               if (hnew > high_ff) high_in = hnew;
            end
            rsp_valid_in = 1'b1;
            rsp_in = '{result_value: 25'(hnew) <<< hmss_pkg::FRAC_W, valid_res: 1'b1,
                       passable: (hnew > cfg.water_level),
                       lowest_seen: low_in, highest_seen: high_in};
         end
         ST_SIDX: begin
            if (corner_ok) begin
               idx_in   = lin[AW-1:0];
               w_in     = (2*(CW+1))'(wa) * (2*(CW+1))'(wb);
               state_in = ST_SRD;
            end else begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in = '{result_value: '0, valid_res: 1'b0, passable: 1'b0,
                          lowest_seen: low_ff, highest_seen: high_ff};
            end
         end
         ST_SRD: state_in = ST_SMUL;
         ST_SMUL: begin
            prod_in  = 45'(rdata_ff) * 45'($signed({1'b0, w_ff}));
            state_in = ST_SACC;
         end
         ST_SACC: begin
            acc_in = acc_ff + prod_ff;
            if (k_ff == 2'd3) begin
               state_in = ST_SFIN;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_SIDX;
            end
         end
         ST_SFIN: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in = '{result_value: q[24:0], valid_res: 1'b1, passable: 1'b0,
                       lowest_seen: low_ff, highest_seen: high_ff};
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         limit_ff     <= (AW+1)'(hmss_pkg::MAX_VERTICES);
         fill_ff      <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         limit_ff     <= limit_in;
         fill_ff      <= fill_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working payload registers.
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      k_ff    <= k_in;
      idx_ff  <= idx_in;
      w_ff    <= w_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   assign init_busy = (state_ff == ST_INIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
